// File: hdl/lpis_pkg.sv
// lpis_pkg: shared widths, payload structs and the level table for the
// luminance palette index selector
// no dependencies
package lpis_pkg;

  localparam int LEVEL_COUNT = 16;              // number of luminance levels, 2..16
  localparam int CH_W        = 8;               // one color channel
  localparam int NUM_CH      = 3;               // red, green, blue
  localparam int IDX_W       = 4;               // level_index width
  localparam int CH_MAX      = (1 << CH_W) - 1; // 255
  localparam int MUL_SHIFT   = 7;               // multiplicative mode shift
  localparam int PROD_W      = 2 * CH_W;
  localparam int CAND_W      = PROD_W - MUL_SHIFT;
  localparam int SQ_W        = 2 * CH_W;
  localparam int ERR_W       = SQ_W + 2;        // sum of three squares
  localparam int CELL_LAT    = 3;               // register stages per cell
  localparam int LATENCY     = LEVEL_COUNT * CELL_LAT;

  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [CAND_W-1:0] cand_t;
  typedef logic [SQ_W-1:0]   sq_t;
  typedef logic [ERR_W-1:0]  err_t;
  typedef logic [IDX_W-1:0]  idx_t;

  // pixel travelling down the chain, with the mode it was accepted under
  typedef struct packed {
    logic                     mode;
    chan_t [NUM_CH-1:0]       base;
    chan_t [NUM_CH-1:0]       src;
  } pix_t;

  // running best match
  typedef struct packed {
    idx_t idx;
    err_t err;
  } best_t;

  // level i is i * 255 / (count - 1), truncated
  function automatic chan_t level_value(input int unsigned i);
    return CH_W'((i * CH_MAX) / (LEVEL_COUNT - 1));
  endfunction

endpackage

// File: hdl/luminance_palette_index_select.sv
// luminance_palette_index_select: top level, config register and the chain
// of per-level cells
// depends on lpis_pkg and lpis_cell
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------------
//  input   | in_base_*, in_src_* (8 bit rgb)         | start & !busy, busy held low
//  result  | out_level_index (4 bit)                 | out_valid strobe, one cycle
//  config  | cfg_wdata (subtractive_mode)            | cfg_we, no wait
//
// one transaction is accepted every clock; each result is carried through the
// three register stages of each level cell, from the first cell to the last
// synchronous active-low reset clears the mode to multiplicative and empties
// the chain; the mode is sampled with each transaction and travels with it
// the receiver cannot stall, so busy never rises
module luminance_palette_index_select (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  lpis_pkg::chan_t       in_base_red,
  input  lpis_pkg::chan_t       in_base_green,
  input  lpis_pkg::chan_t       in_base_blue,
  input  lpis_pkg::chan_t       in_src_red,
  input  lpis_pkg::chan_t       in_src_green,
  input  lpis_pkg::chan_t       in_src_blue,
  output logic                  out_valid,
  output lpis_pkg::idx_t        out_level_index,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata
);

  // subtractive mode register
  logic mode_r, mode_nxt;

  // chain links, entry 0 feeds the first cell
  logic            vld  [lpis_pkg::LEVEL_COUNT+1];
  lpis_pkg::pix_t  pix  [lpis_pkg::LEVEL_COUNT+1];
  lpis_pkg::best_t best [lpis_pkg::LEVEL_COUNT+1];

  assign mode_nxt = cfg_we ? cfg_wdata : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // the chain always flows
  assign busy = 1'b0;

  // head of chain: the pixel with an empty best (worse than any real error)
  assign vld[0]          = start;
  assign pix[0].mode     = mode_r;
  assign pix[0].base[0]  = in_base_red;
  assign pix[0].base[1]  = in_base_green;
  assign pix[0].base[2]  = in_base_blue;
  assign pix[0].src[0]   = in_src_red;
  assign pix[0].src[1]   = in_src_green;
  assign pix[0].src[2]   = in_src_blue;
  assign best[0].idx     = '0;
  assign best[0].err     = '1;

  // one cell per level, each scoring its own level against the pixel
  for (genvar g = 0; g < lpis_pkg::LEVEL_COUNT; g++) begin : g_cell
    lpis_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .lev      (lpis_pkg::level_value(g)),
      .idx      (lpis_pkg::IDX_W'(g)),
      .in_vld   (vld[g]),
      .in_pix   (pix[g]),
      .in_best  (best[g]),
      .out_vld  (vld[g+1]),
      .out_pix  (pix[g+1]),
      .out_best (best[g+1])
    );
  end

  assign out_valid       = vld[lpis_pkg::LEVEL_COUNT];
  assign out_level_index = best[lpis_pkg::LEVEL_COUNT].idx;

  // level 0 always gives a usable candidate, so the best must have been set
  a_best_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (best[lpis_pkg::LEVEL_COUNT].err != '1))
    else $error("result left the chain without a scored level");

  // an index beyond the level table can never win
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_level_index) < lpis_pkg::LEVEL_COUNT))
    else $error("level index out of range");

  // black base gives identical candidates in both modes, so index 0 must win
  a_black_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (pix[lpis_pkg::LEVEL_COUNT].base == '0)) |->
      (out_level_index == '0))
    else $error("tie on black base did not keep the lowest index");

  // in subtractive mode, an exact match of a pixel against itself scores zero error at level 0
  a_exact_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && pix[lpis_pkg::LEVEL_COUNT].mode &&
     (pix[lpis_pkg::LEVEL_COUNT].base == pix[lpis_pkg::LEVEL_COUNT].src)) |->
      ((out_level_index == '0) && (best[lpis_pkg::LEVEL_COUNT].err == '0)))
    else $error("exact match in subtractive mode not chosen at level 0");

endmodule

// File: hdl/lpis_cell.sv
// lpis_cell: one level of the selector chain; builds the candidate for its
// level, scores it against the source and updates the running best
// depends on lpis_pkg
module lpis_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lpis_pkg::chan_t     lev,
  input  lpis_pkg::idx_t      idx,
  input  logic                in_vld,
  input  lpis_pkg::pix_t      in_pix,
  input  lpis_pkg::best_t     in_best,
  output logic                out_vld,
  output lpis_pkg::pix_t      out_pix,
  output lpis_pkg::best_t     out_best
);

  // stage 1: candidate color
  logic                                  s1_vld_r;
  lpis_pkg::pix_t                        s1_pix_r;
  lpis_pkg::best_t                       s1_best_r;
  lpis_pkg::cand_t [lpis_pkg::NUM_CH-1:0] s1_cand_r, s1_cand_nxt;

  // stage 2: squared channel errors
  logic                                  s2_vld_r;
  lpis_pkg::pix_t                        s2_pix_r;
  lpis_pkg::best_t                       s2_best_r;
  logic                                  s2_ok_r, s2_ok_nxt;
  lpis_pkg::sq_t [lpis_pkg::NUM_CH-1:0]  s2_sq_r, s2_sq_nxt;

  // stage 3: compare
  logic                                  s3_vld_r;
  lpis_pkg::pix_t                        s3_pix_r;
  lpis_pkg::best_t                       s3_best_r, s3_best_nxt;
  lpis_pkg::err_t                        err_sum;

  always_comb begin
    logic [lpis_pkg::PROD_W-1:0] prod;
    for (int c = 0; c < lpis_pkg::NUM_CH; c++) begin
      prod = {{lpis_pkg::CH_W{1'b0}}, in_pix.base[c]} * {{lpis_pkg::CH_W{1'b0}}, lev};
      if (in_pix.mode) begin
        if (in_pix.base[c] > lev) begin
          s1_cand_nxt[c] = lpis_pkg::CAND_W'(in_pix.base[c] - lev);
        end else begin
          s1_cand_nxt[c] = '0;
        end
      end else begin
        s1_cand_nxt[c] = prod[lpis_pkg::PROD_W-1:lpis_pkg::MUL_SHIFT];
      end
    end
  end

  always_comb begin
    lpis_pkg::chan_t cv;
    lpis_pkg::chan_t diff;
    s2_ok_nxt = 1'b1;
    for (int c = 0; c < lpis_pkg::NUM_CH; c++) begin
      // candidate above full scale is not usable
      if (s1_cand_r[c][lpis_pkg::CAND_W-1:lpis_pkg::CH_W] != '0) begin
        s2_ok_nxt = 1'b0;
      end
      cv = s1_cand_r[c][lpis_pkg::CH_W-1:0];
      if (cv >= s1_pix_r.src[c]) begin
        diff = cv - s1_pix_r.src[c];
      end else begin
        diff = s1_pix_r.src[c] - cv;
      end
      s2_sq_nxt[c] = {{lpis_pkg::CH_W{1'b0}}, diff} * {{lpis_pkg::CH_W{1'b0}}, diff};
    end
  end

  always_comb begin
    err_sum = lpis_pkg::ERR_W'(s2_sq_r[0]) + lpis_pkg::ERR_W'(s2_sq_r[1])
            + lpis_pkg::ERR_W'(s2_sq_r[2]);
    // strict compare keeps the lower index on ties
    if (s2_ok_r && (err_sum < s2_best_r.err)) begin
      s3_best_nxt.idx = idx;
      s3_best_nxt.err = err_sum;
    end else begin
      s3_best_nxt = s2_best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r  <= in_pix;
    s1_best_r <= in_best;
    s1_cand_r <= s1_cand_nxt;
    s2_pix_r  <= s1_pix_r;
    s2_best_r <= s1_best_r;
    s2_ok_r   <= s2_ok_nxt;
    s2_sq_r   <= s2_sq_nxt;
    s3_pix_r  <= s2_pix_r;
    s3_best_r <= s3_best_nxt;
  end

  assign out_vld  = s3_vld_r;
  assign out_pix  = s3_pix_r;
  assign out_best = s3_best_r;

endmodule

// File: bench/lpis_index_checker.sv
// lpis_index_checker: watches the input, result and config channels of the
// luminance palette index selector, predicts each level index and compares
// depends on lpis_pkg only
module lpis_index_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  lpis_pkg::chan_t  in_base_red,
  input  lpis_pkg::chan_t  in_base_green,
  input  lpis_pkg::chan_t  in_base_blue,
  input  lpis_pkg::chan_t  in_src_red,
  input  lpis_pkg::chan_t  in_src_green,
  input  lpis_pkg::chan_t  in_src_blue,
  input  logic             out_valid,
  input  lpis_pkg::idx_t   out_level_index,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  output int               mismatch_count,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHAN_TOP  = 255;
  localparam int unsigned MUL_SHR   = 7;

  typedef struct {
    logic                       sub_mode;
    lpis_pkg::chan_t [2:0]      base;
    lpis_pkg::chan_t [2:0]      src;
    lpis_pkg::idx_t             level_index;
  } pixel_expect_t;

  pixel_expect_t expected_idx_q[$];
  logic          sub_mode;
  int            errs = 0;

  // best luminance level: lowest summed squared error, lowest index on ties,
  // multiplicative candidates with a channel above 255 are skipped
  function automatic lpis_pkg::idx_t best_level_index(input logic sub,
                                                      input lpis_pkg::chan_t [2:0] base,
                                                      input lpis_pkg::chan_t [2:0] src);
    int unsigned    lev, cand, diff, err, best_err;
    lpis_pkg::idx_t best;
    bit             have_best, fits;
    best      = '0;
    best_err  = 0;
    have_best = 1'b0;
    for (int i = 0; i < lpis_pkg::LEVEL_COUNT; i++) begin
      lev  = (i * CHAN_TOP) / (lpis_pkg::LEVEL_COUNT - 1);
      err  = 0;
      fits = 1'b1;
      for (int k = 0; k < 3; k++) begin
        if (sub) begin
          cand = (base[k] > lev) ? base[k] - lev : 0;
        end else begin
          cand = (base[k] * lev) >> MUL_SHR;
        end
        if (cand > CHAN_TOP) fits = 1'b0;
        diff = (cand >= src[k]) ? cand - src[k] : src[k] - cand;
        err += diff * diff;
      end
      if (fits && (!have_best || err < best_err)) begin
        have_best = 1'b1;
        best_err  = err;
        best      = lpis_pkg::idx_t'(i);
      end
    end
    return best;
  endfunction

  task automatic report_mismatch(input string what);
    errs++;
    $display("%0t lpis mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : watch
    pixel_expect_t head, pix;
    if (!rst_n) begin
      sub_mode = 1'b0;
      expected_idx_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_idx_q.size() == 0) begin
          report_mismatch($sformatf("level_index %0d with no transaction waiting",
                                    out_level_index));
        end else begin
          head = expected_idx_q.pop_front();
          if (out_level_index !== head.level_index) begin
            report_mismatch($sformatf(
              "mode %0d base %0d/%0d/%0d src %0d/%0d/%0d: level_index %0d, expected %0d",
              head.sub_mode, head.base[0], head.base[1], head.base[2],
              head.src[0], head.src[1], head.src[2], out_level_index, head.level_index));
          end
        end
      end
      if (start && !busy) begin
        pix.sub_mode    = sub_mode;
        pix.base        = {in_base_blue, in_base_green, in_base_red};
        pix.src         = {in_src_blue, in_src_green, in_src_red};
        pix.level_index = best_level_index(pix.sub_mode, pix.base, pix.src);
        expected_idx_q.push_back(pix);
      end
      // mode applies from the next transaction on
      if (cfg_we) sub_mode = cfg_wdata;
    end
    outstanding    <= expected_idx_q.size();
    mismatch_count <= errs;
  end

endmodule

// File: bench/tb_luminance_palette_index_select.sv
// tb_luminance_palette_index_select: stimulus and verdict for the luminance
// palette index selector, directed pixels then random ones in both modes
// depends on lpis_pkg, luminance_palette_index_select and lpis_index_checker
module tb_luminance_palette_index_select;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 230;     // about 1150 random transactions in all
  localparam int CYCLE_LIMIT  = 300000;  // worst case stays well under this limit

  typedef struct packed {
    lpis_pkg::chan_t br, bg, bb;
    lpis_pkg::chan_t sr, sg, sb;
  } pixel_t;

  // directed pixels, each run under both modes
  localparam pixel_t DIRECTED [12] = '{
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },  // all zero, every level ties
    '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},  // all full scale
    '{8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0  },  // bright base, black source
    '{8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255},  // black base, white source
    '{8'd128, 8'd128, 8'd128, 8'd85,  8'd85,  8'd85 },  // exact level 5 when multiplying
    '{8'd128, 8'd128, 8'd128, 8'd255, 8'd255, 8'd255},  // exact top level when multiplying
    '{8'd255, 8'd255, 8'd255, 8'd238, 8'd238, 8'd238},  // exact level 1 when subtracting
    '{8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0  },  // overflow on one channel only
    '{8'd20,  8'd20,  8'd20,  8'd0,   8'd0,   8'd0  },  // clamp ties from level 2 up
    '{8'd1,   8'd2,   8'd3,   8'd255, 8'd255, 8'd255},
    '{8'd255, 8'd128, 8'd1,   8'd0,   8'd128, 8'd255},  // mixed channels
    '{8'd170, 8'd85,  8'd34,  8'd200, 8'd100, 8'd40 }
  };

  logic            clk   = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  lpis_pkg::chan_t in_base_red   = '0;
  lpis_pkg::chan_t in_base_green = '0;
  lpis_pkg::chan_t in_base_blue  = '0;
  lpis_pkg::chan_t in_src_red    = '0;
  lpis_pkg::chan_t in_src_green  = '0;
  lpis_pkg::chan_t in_src_blue   = '0;
  logic            out_valid;
  lpis_pkg::idx_t  out_level_index;
  logic            cfg_we    = 1'b0;
  logic            cfg_wdata = 1'b0;

  int    mismatch_count;
  int    outstanding;
  logic  cur_mode = 1'b0;   // mode last written, used to shape the stimulus
  int    burst_left = 0;    // transactions left in a back-to-back stretch
  int    cycle_cnt = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  luminance_palette_index_select u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_base_red     (in_base_red),
    .in_base_green   (in_base_green),
    .in_base_blue    (in_base_blue),
    .in_src_red      (in_src_red),
    .in_src_green    (in_src_green),
    .in_src_blue     (in_src_blue),
    .out_valid       (out_valid),
    .out_level_index (out_level_index),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  lpis_index_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_base_red     (in_base_red),
    .in_base_green   (in_base_green),
    .in_base_blue    (in_base_blue),
    .in_src_red      (in_src_red),
    .in_src_green    (in_src_green),
    .in_src_blue     (in_src_blue),
    .out_valid       (out_valid),
    .out_level_index (out_level_index),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding)
  );

  // present one transaction and hold it until the block takes it
  task automatic drive_pixel(input pixel_t p);
    start         <= 1'b1;
    in_base_red   <= p.br;
    in_base_green <= p.bg;
    in_base_blue  <= p.bb;
    in_src_red    <= p.sr;
    in_src_green  <= p.sg;
    in_src_blue   <= p.sb;
    do @(posedge clk); while (busy);
  endtask

  // gap after a transaction: mostly none or short, now and then long,
  // with occasional back-to-back stretches
  task automatic pause_sender();
    int r, gap;
    r = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      gap = 0;
    end else if (r < 55) begin
      gap = 0;
    end else if (r < 85) begin
      gap = $urandom_range(1, 3);
    end else if (r < 97) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      // junk on the payload while start is low must be ignored
      start         <= 1'b0;
      in_base_red   <= lpis_pkg::chan_t'($urandom);
      in_base_green <= lpis_pkg::chan_t'($urandom);
      in_base_blue  <= lpis_pkg::chan_t'($urandom);
      in_src_red    <= lpis_pkg::chan_t'($urandom);
      in_src_green  <= lpis_pkg::chan_t'($urandom);
      in_src_blue   <= lpis_pkg::chan_t'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop start and hold off until every result has come back; the extra
  // edge first lets the checker count a transaction taken at this edge
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // only called with the block idle
  task automatic write_mode(input logic m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_mode  = m;
  endtask

  // source channel close to the candidate of one level, so that neighbors
  // compete; overflowing candidates are pinned at full scale
  function automatic lpis_pkg::chan_t near_candidate(input lpis_pkg::chan_t base,
                                                     input int lev);
    int c;
    if (cur_mode) begin
      c = (base > lev) ? base - lev : 0;
    end else begin
      c = (base * lev) >> 7;
    end
    if (c > 255) c = 255;
    c = c + $urandom_range(0, 6) - 3;
    if (c < 0) c = 0;
    if (c > 255) c = 255;
    return lpis_pkg::chan_t'(c);
  endfunction

  function automatic lpis_pkg::chan_t edge_value();
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd254;
      5: return 8'd255;
      default: return lpis_pkg::chan_t'($urandom);
    endcase
  endfunction

  function automatic pixel_t make_random_pixel();
    pixel_t p;
    int     kind, lev;
    kind = $urandom_range(0, 99);
    p    = pixel_t'({$urandom, $urandom});
    if (kind < 40) begin
      // source near one level's candidate
      lev  = ($urandom_range(0, lpis_pkg::LEVEL_COUNT - 1) * 255)
             / (lpis_pkg::LEVEL_COUNT - 1);
      p.sr = near_candidate(p.br, lev);
      p.sg = near_candidate(p.bg, lev);
      p.sb = near_candidate(p.bb, lev);
    end else if (kind < 60) begin
      // plain random, already in p
    end else if (kind < 78) begin
      p.br = edge_value();
      p.bg = edge_value();
      p.bb = edge_value();
      p.sr = edge_value();
      p.sg = edge_value();
      p.sb = edge_value();
    end else if (kind < 89) begin
      // dim base: many candidates collapse onto the same value, ties galore
      p.br = lpis_pkg::chan_t'($urandom_range(0, 24));
      p.bg = lpis_pkg::chan_t'($urandom_range(0, 24));
      p.bb = lpis_pkg::chan_t'($urandom_range(0, 24));
      p.sr = lpis_pkg::chan_t'($urandom_range(0, 8));
      p.sg = lpis_pkg::chan_t'($urandom_range(0, 8));
      p.sb = lpis_pkg::chan_t'($urandom_range(0, 8));
    end else begin
      // bright base and source: upper levels overflow when multiplying
      p.br = lpis_pkg::chan_t'($urandom_range(180, 255));
      p.bg = lpis_pkg::chan_t'($urandom_range(180, 255));
      p.bb = lpis_pkg::chan_t'($urandom_range(180, 255));
      p.sr = lpis_pkg::chan_t'($urandom_range(200, 255));
      p.sg = lpis_pkg::chan_t'($urandom_range(200, 255));
      p.sb = lpis_pkg::chan_t'($urandom_range(200, 255));
    end
    return p;
  endfunction

  // watchdog: a missing result or a stuck busy ends here
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_luminance_palette_index_select: done, errors");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed pixels under the reset mode (multiplicative), then subtractive
    foreach (DIRECTED[i]) begin
      drive_pixel(DIRECTED[i]);
      pause_sender();
    end
    wait_for_results();
    write_mode(1'b1);
    foreach (DIRECTED[i]) begin
      drive_pixel(DIRECTED[i]);
      pause_sender();
    end
    wait_for_results();

    // random phases, alternating the mode between them
    for (int ph = 0; ph < PHASES; ph++) begin
      write_mode(ph[0]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // halfway through, the sender stops until the pipeline has drained
        if (n == PHASE_ITEMS / 2) wait_for_results();
        drive_pixel(make_random_pixel());
        pause_sender();
      end
      wait_for_results();
    end

    // catch stray results beyond the last expected one
    repeat (lpis_pkg::LATENCY + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_luminance_palette_index_select: done, clean");
    end else begin
      $display("tb_luminance_palette_index_select: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/lpis_pkg.sv
hdl/lpis_cell.sv
hdl/luminance_palette_index_select.sv
bench/lpis_index_checker.sv
bench/tb_luminance_palette_index_select.sv
